@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen on a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLKD(label, !(cond), msg)

`endif

@@ hw/rtl/dda_lr_pkg.sv @@
// Constants and types shared by the DDA line rasteriser and its checker.
package dda_lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_BITS   = 12;
  localparam int ADDR_BITS  = 22;
  localparam int COLOR_BITS = 32;

  localparam int DELTA_W   = COORD_BITS + 1;
  localparam int MAG_W     = COORD_BITS;
  localparam int PIX_W     = COORD_BITS + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int STEP_W    = FRAC_BITS + 2;
  localparam int ACC_W     = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(Q_W);
  localparam int PROD_W    = COORD_BITS + DIM_BITS;
  localparam int CFG_IDX_W = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SCREEN_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SCREEN_HEIGHT = cfg_idx_t'(1);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(600);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

endpackage

@@ hw/rtl/dda_line_rasterizer.sv @@
// DDA line rasteriser: line set-up with a shared iterative divider, then one pixel per step.
//
// A load transaction (req_type 0) takes two endpoints and a colour and sets up a line: the
// step count is max(|dx|,|dy|) and each increment is delta/count in fixed point with
// FRAC_BITS fraction bits, truncated toward zero. Both increments come out of one shared
// restoring divider, one quotient bit per cycle, x first and then y, so a load holds
// in_ready_o low after it is taken until both divisions are done.
// A step transaction (req_type 1) produces one pixel: the accumulators rounded half away
// from zero, a visibility flag against screen_width/screen_height, the address
// y*screen_width+x (zero when not visible), the colour and a last-pixel flag. A step
// goes through round and advance, then the address multiply into the output register, and
// waits while the previous pixel is still waiting in the output register. A step with no
// line active is accepted and produces nothing. A zero-length line gives its
// start pixel once, flagged last. Configuration writes via cfg_we_i/cfg_index_i/
// cfg_data_i take effect at once and must only be issued while the block is idle.
module dda_line_rasterizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  dda_lr_pkg::cfg_idx_t                cfg_index_i,
  input  logic [dda_lr_pkg::DIM_BITS-1:0]     cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [dda_lr_pkg::COORD_BITS-1:0]   x_start_i,
  input  logic [dda_lr_pkg::COORD_BITS-1:0]   y_start_i,
  input  logic [dda_lr_pkg::COORD_BITS-1:0]   x_end_i,
  input  logic [dda_lr_pkg::COORD_BITS-1:0]   y_end_i,
  input  logic [dda_lr_pkg::COLOR_BITS-1:0]   pixel_color_i,
  // pixel channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dda_lr_pkg::COORD_BITS-1:0]   pixel_x_o,
  output logic [dda_lr_pkg::COORD_BITS-1:0]   pixel_y_o,
  output logic [dda_lr_pkg::ADDR_BITS-1:0]    pixel_address_o,
  output logic                                visible_o,
  output logic [dda_lr_pkg::COLOR_BITS-1:0]   write_color_o,
  output logic                                last_pixel_o
);
  import dda_lr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_PIX,
    ST_EMIT
  } state_e;

  // round half away from zero to an integer coordinate
  function automatic logic [PIX_W-1:0] round_acc(input logic [ACC_W-1:0] a);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    logic [PIX_W-1:0] r;
    mag = a[ACC_W-1] ? (~a + ACC_W'(1)) : a;
    sum = mag + (ACC_W'(1) << (FRAC_BITS - 1));
    r   = sum[ACC_W-1:FRAC_BITS];
    return a[ACC_W-1] ? (~r + PIX_W'(1)) : r;
  endfunction

  state_e                 state_q, state_d;
  logic [DIM_BITS-1:0]    width_q, width_d;
  logic [DIM_BITS-1:0]    height_q, height_d;
  logic [ACC_W-1:0]       acc_x_q, acc_x_d;
  logic [ACC_W-1:0]       acc_y_q, acc_y_d;
  logic [STEP_W-1:0]      step_x_q, step_x_d;
  logic [STEP_W-1:0]      step_y_q, step_y_d;
  logic [MAG_W-1:0]       steps_q, steps_d;
  logic [COLOR_BITS-1:0]  color_q, color_d;
  logic                   active_q, active_d;
  // divider state
  logic [MAG_W-1:0]       ay_q, ay_d;
  logic                   neg_x_q, neg_x_d;
  logic                   neg_y_q, neg_y_d;
  logic [MAG_W-1:0]       rem_q, rem_d;
  logic [Q_W-1:0]         quot_q, quot_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  // pixel pipeline
  logic [PIX_W-1:0]       px_q, px_d;
  logic [PIX_W-1:0]       py_q, py_d;
  logic                   last_q, last_d;
  // output register
  logic                   out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]  pix_x_q, pix_x_d;
  logic [COORD_BITS-1:0]  pix_y_q, pix_y_d;
  logic [ADDR_BITS-1:0]   addr_q, addr_d;
  logic                   vis_q, vis_d;
  logic [COLOR_BITS-1:0]  wcolor_q, wcolor_d;
  logic                   olast_q, olast_d;

  // load set-up
  logic [DELTA_W-1:0]     dx, dy, adx, ady;
  logic [MAG_W-1:0]       ax, ay, side;
  // shared divider unit
  logic [MAG_W:0]         trial;
  logic [MAG_W+1:0]       diff;
  logic                   ge;
  logic [Q_W-1:0]         quot_fin;
  logic [STEP_W-1:0]      q_ext, q_signed;
  logic                   div_last;
  // emit
  logic                   vis;
  logic [PROD_W-1:0]      prod;
  logic                   slot_free;
  logic                   in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign dx   = {x_end_i[COORD_BITS-1], x_end_i} - {x_start_i[COORD_BITS-1], x_start_i};
  assign dy   = {y_end_i[COORD_BITS-1], y_end_i} - {y_start_i[COORD_BITS-1], y_start_i};
  assign adx  = dx[DELTA_W-1] ? (~dx + DELTA_W'(1)) : dx;
  assign ady  = dy[DELTA_W-1] ? (~dy + DELTA_W'(1)) : dy;
  assign ax   = adx[MAG_W-1:0];
  assign ay   = ady[MAG_W-1:0];
  assign side = (ax >= ay) ? ax : ay;

  // restoring step: first pass compares the magnitude itself (integer bit of the quotient),
  // later passes shift in a zero fraction bit
  assign trial    = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign diff     = {1'b0, trial} - {2'b00, steps_q};
  assign ge       = !diff[MAG_W+1];
  assign quot_fin = {quot_q[Q_W-2:0], ge};
  assign div_last = (cnt_q == CNT_W'(Q_W - 1));
  assign q_ext    = (steps_q == '0) ? '0 : {1'b0, quot_fin};
  assign q_signed = ((state_q == ST_DIV_X) ? neg_x_q : neg_y_q) ? (~q_ext + STEP_W'(1)) : q_ext;

  assign vis  = !px_q[PIX_W-1] && !py_q[PIX_W-1]
             && (PROD_W'(px_q[COORD_BITS-1:0]) < PROD_W'(width_q))
             && (PROD_W'(py_q[COORD_BITS-1:0]) < PROD_W'(height_q));
  assign prod = PROD_W'(py_q[COORD_BITS-1:0]) * PROD_W'(width_q);

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    steps_d     = steps_q;
    color_d     = color_q;
    active_d    = active_q;
    ay_d        = ay_q;
    neg_x_d     = neg_x_q;
    neg_y_d     = neg_y_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    addr_d      = addr_q;
    vis_d       = vis_q;
    wcolor_d    = wcolor_q;
    olast_d     = olast_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  width_d  = cfg_data_i;
        REG_SCREEN_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i == REQ_LOAD) begin
            acc_x_d  = {x_start_i[COORD_BITS-1], x_start_i, FRAC_BITS'(0)};
            acc_y_d  = {y_start_i[COORD_BITS-1], y_start_i, FRAC_BITS'(0)};
            steps_d  = side;
            color_d  = pixel_color_i;
            active_d = 1'b1;
            ay_d     = ay;
            neg_x_d  = dx[DELTA_W-1];
            neg_y_d  = dy[DELTA_W-1];
            rem_d    = ax;
            quot_d   = '0;
            cnt_d    = '0;
            state_d  = ST_DIV_X;
          end else if (active_q) begin
            state_d = ST_PIX;
          end
        end
      end
      ST_DIV_X, ST_DIV_Y: begin
        rem_d  = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        quot_d = quot_fin;
        cnt_d  = cnt_q + CNT_W'(1);
        if (div_last) begin
          cnt_d  = '0;
          quot_d = '0;
          if (state_q == ST_DIV_X) begin
            step_x_d = q_signed;
            rem_d    = ay_q;
            state_d  = ST_DIV_Y;
          end else begin
            step_y_d = q_signed;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_PIX: begin
        px_d   = round_acc(acc_x_q);
        py_d   = round_acc(acc_y_q);
        last_d = (steps_q == '0);
        if (steps_q == '0) begin
          active_d = 1'b0;
        end else begin
          acc_x_d = acc_x_q + {{(ACC_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
          acc_y_d = acc_y_q + {{(ACC_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
          steps_d = steps_q - MAG_W'(1);
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          pix_x_d     = px_q[COORD_BITS-1:0];
          pix_y_d     = py_q[COORD_BITS-1:0];
          vis_d       = vis;
          addr_d      = vis ? ADDR_BITS'(prod + PROD_W'(px_q[COORD_BITS-1:0])) : '0;
          wcolor_d    = color_q;
          olast_d     = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      steps_q     <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      step_x_q    <= step_x_d;
      step_y_q    <= step_y_d;
      steps_q     <= steps_d;
      color_q     <= color_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    ay_q     <= ay_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    px_q     <= px_d;
    py_q     <= py_d;
    last_q   <= last_d;
    pix_x_q  <= pix_x_d;
    pix_y_q  <= pix_y_d;
    addr_q   <= addr_d;
    vis_q    <= vis_d;
    wcolor_q <= wcolor_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = pix_x_q;
  assign pixel_y_o       = pix_y_q;
  assign pixel_address_o = addr_q;
  assign visible_o       = vis_q;
  assign write_color_o   = wcolor_q;
  assign last_pixel_o    = olast_q;

endmodule

@@ hw/rtl/dda_lr_checker.sv @@
// Port-level checker for the DDA line rasteriser, bound to the top level.
`include "assert_macros.svh"

module dda_lr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               req_type_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [dda_lr_pkg::COORD_BITS-1:0]  pixel_x_o,
  input logic [dda_lr_pkg::COORD_BITS-1:0]  pixel_y_o,
  input logic [dda_lr_pkg::ADDR_BITS-1:0]   pixel_address_o,
  input logic                               visible_o
);
  import dda_lr_pkg::*;

  // a pending pixel is held until taken
  `ASSERT_CLKD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "pixel dropped")
  // hidden pixels carry a zero address
  `ASSERT_NEVER(a_hidden_addr, out_valid_o && !visible_o && pixel_address_o != '0, "addr set")
  // visible pixels have non-negative coordinates
  `ASSERT_NEVER(a_vis_sign, out_valid_o && visible_o && (pixel_x_o[COORD_BITS-1] || pixel_y_o[COORD_BITS-1]), "neg vis")
  // a load keeps the request side busy while the divider runs
  `ASSERT_CLKD(a_load_busy, in_valid_i && in_ready_o && req_type_i == REQ_LOAD |=> !in_ready_o, "load not busy")

endmodule

bind dda_line_rasterizer dda_lr_checker u_dda_lr_checker (.*);

@@ sim/dda_line_rasterizer_tb.sv @@
// Self-checking testbench for the DDA line rasteriser: queued stimulus, predictor and pixel checker.
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;
  import dda_lr_pkg::*;

  // Timing of the run
  localparam int SETTLE_CYCLES = 60;    // a load holds input while dividing, a step until it emits
  localparam int HOLD_CYCLES   = 400;   // long receiver stall, enough to back up the input
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction before giving up
  localparam int RANDOM_ITEMS  = 1830;
  localparam int NUM_PHASES    = 6;

  // One request transaction as offered on the input channel
  typedef struct {
    logic                          req;
    logic signed [COORD_BITS-1:0]  xs;
    logic signed [COORD_BITS-1:0]  ys;
    logic signed [COORD_BITS-1:0]  xe;
    logic signed [COORD_BITS-1:0]  ye;
    logic [COLOR_BITS-1:0]         colour;
  } line_req_t;

  // One pixel transaction as produced on the output channel
  typedef struct {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [ADDR_BITS-1:0]   addr;
    logic                   vis;
    logic [COLOR_BITS-1:0]  colour;
    logic                   last;
  } pixel_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Block inputs, all known from time zero
  logic                   cfg_we    = 1'b0;
  cfg_idx_t               cfg_index = REG_SCREEN_WIDTH;
  logic [DIM_BITS-1:0]    cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   req_type  = REQ_STEP;
  logic [COORD_BITS-1:0]  x_start   = '0;
  logic [COORD_BITS-1:0]  y_start   = '0;
  logic [COORD_BITS-1:0]  x_end     = '0;
  logic [COORD_BITS-1:0]  y_end     = '0;
  logic [COLOR_BITS-1:0]  colour_in = '0;
  logic                   out_ready = 1'b0;

  // Block outputs
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [COORD_BITS-1:0]  pixel_x_o;
  logic [COORD_BITS-1:0]  pixel_y_o;
  logic [ADDR_BITS-1:0]   pixel_address_o;
  logic                   visible_o;
  logic [COLOR_BITS-1:0]  write_color_o;
  logic                   last_pixel_o;

  // Stimulus and scoreboard
  line_req_t  pending_items[$];
  pixel_t     expected_pixels[$];
  line_req_t  on_wire;
  pixel_t     next_pixel;
  pixel_t     want;
  int         items_queued  = 0;
  int         send_idle_pct = 17;
  int         recv_idle_pct = 17;
  int         errors        = 0;
  int         pixels_seen   = 0;
  int         hold_left     = 0;
  int         quiet_cycles  = 0;

  // Predictor: screen size copy and line state
  logic [DIM_BITS-1:0]            screen_w = WIDTH_RESET;
  logic [DIM_BITS-1:0]            screen_h = HEIGHT_RESET;
  logic signed [ACC_W-1:0]        acc_x    = '0;
  logic signed [ACC_W-1:0]        acc_y    = '0;
  logic signed [STEP_W-1:0]       inc_x    = '0;
  logic signed [STEP_W-1:0]       inc_y    = '0;
  logic [COORD_BITS:0]            steps_left  = '0;
  logic [COLOR_BITS-1:0]          line_colour = '0;
  bit                             line_live   = 1'b0;

  dda_line_rasterizer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type),
    .x_start_i       (x_start),
    .y_start_i       (y_start),
    .x_end_i         (x_end),
    .y_end_i         (y_end),
    .pixel_color_i   (colour_in),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .visible_o       (visible_o),
    .write_color_o   (write_color_o),
    .last_pixel_o    (last_pixel_o)
  );

  // 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // delta/count in fixed point, quotient truncated toward zero
  function automatic logic signed [STEP_W-1:0] fixed_increment(input int delta, input int count);
    longint q;
    if (count == 0) return '0;
    q = (longint'((delta < 0) ? -delta : delta) << FRAC_BITS) / count;
    return STEP_W'((delta < 0) ? -q : q);
  endfunction

  // accumulator to integer, halves go away from zero
  function automatic int round_half_away(input logic signed [ACC_W-1:0] a);
    longint wide;
    longint mag;
    wide = a;
    mag  = ((wide < 0) ? -wide : wide) + (longint'(1) << (FRAC_BITS - 1));
    mag  = mag >> FRAC_BITS;
    return (wide < 0) ? -int'(mag) : int'(mag);
  endfunction

  // Applies one accepted request; returns 1 with the pixel when one is due.
  function automatic bit dda_advance(input line_req_t r, output pixel_t p);
    int x0;
    int y0;
    int dx;
    int dy;
    int side;
    int px;
    int py;
    bit vis;
    p = '{default: '0};
    if (r.req == REQ_LOAD) begin
      x0   = r.xs;
      y0   = r.ys;
      dx   = int'(r.xe) - x0;
      dy   = int'(r.ye) - y0;
      side = ((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy) ?
             ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
      acc_x       = ACC_W'(x0 * (1 << FRAC_BITS));
      acc_y       = ACC_W'(y0 * (1 << FRAC_BITS));
      inc_x       = fixed_increment(dx, side);
      inc_y       = fixed_increment(dy, side);
      steps_left  = (COORD_BITS+1)'(side);
      line_colour = r.colour;
      line_live   = 1'b1;
      return 1'b0;
    end
    // a step with no line in progress is swallowed
    if (!line_live) return 1'b0;
    px  = round_half_away(acc_x);
    py  = round_half_away(acc_y);
    vis = px >= 0 && py >= 0 && px < int'(screen_w) && py < int'(screen_h);
    p.x      = COORD_BITS'(px);
    p.y      = COORD_BITS'(py);
    p.addr   = vis ? ADDR_BITS'(py * int'(screen_w) + px) : '0;
    p.vis    = vis;
    p.colour = line_colour;
    p.last   = (steps_left == 0);
    if (p.last) begin
      line_live = 1'b0;
    end else begin
      acc_x      = acc_x + inc_x;
      acc_y      = acc_y + inc_y;
      steps_left = steps_left - 1'b1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Step with junk in the coordinate and colour fields; the block must ignore them.
  task automatic queue_step();
    line_req_t r;
    r.req    = REQ_STEP;
    r.xs     = COORD_BITS'($urandom);
    r.ys     = COORD_BITS'($urandom);
    r.xe     = COORD_BITS'($urandom);
    r.ye     = COORD_BITS'($urandom);
    r.colour = $urandom;
    pending_items.push_back(r);
    items_queued++;
  endtask

  // A load followed by a given number of steps
  task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
                            input logic [COLOR_BITS-1:0] colour, input int n_steps);
    line_req_t r;
    r.req    = REQ_LOAD;
    r.xs     = COORD_BITS'(xs);
    r.ys     = COORD_BITS'(ys);
    r.xe     = COORD_BITS'(xe);
    r.ye     = COORD_BITS'(ye);
    r.colour = colour;
    pending_items.push_back(r);
    items_queued++;
    repeat (n_steps) queue_step();
  endtask

  // Random line, mostly short and near the screen. Most are drawn to the end; some are cut
  // short by the next load and some run on with steps after the last pixel.
  task automatic queue_random_line();
    int xs;
    int ys;
    int xe;
    int ye;
    int dx;
    int dy;
    int span;
    int side;
    int n_steps;
    int pick;
    if ($urandom_range(7) == 0) begin
      xs = int'($urandom_range(4095)) - 2048;
      ys = int'($urandom_range(4095)) - 2048;
    end else begin
      xs = int'($urandom_range(((screen_w < 40) ? 40 : int'(screen_w)) + 40)) - 20;
      ys = int'($urandom_range(((screen_h < 40) ? 40 : int'(screen_h)) + 40)) - 20;
      if (xs > 2047) xs = 2047;
      if (ys > 2047) ys = 2047;
    end
    pick = $urandom_range(19);
    span = (pick < 14) ? 12 : (pick < 19) ? 60 : 300;
    dx = int'($urandom_range(2 * span)) - span;
    dy = int'($urandom_range(2 * span)) - span;
    xe = (xs + dx > 2047 || xs + dx < -2048) ? xs - dx : xs + dx;
    ye = (ys + dy > 2047 || ys + dy < -2048) ? ys - dy : ys + dy;
    dx = (xe > xs) ? xe - xs : xs - xe;
    dy = (ye > ys) ? ye - ys : ys - ye;
    side = (dx > dy) ? dx : dy;
    pick = $urandom_range(99);
    if (pick < 85) n_steps = side + 1;
    else if (pick < 93) n_steps = $urandom_range(side);
    else n_steps = side + 1 + $urandom_range(1, 3);
    queue_line(xs, ys, xe, ye, $urandom, n_steps);
  endtask

  // Fully random transaction
  task automatic queue_noise();
    line_req_t r;
    r.req    = 1'($urandom_range(1));
    r.xs     = COORD_BITS'($urandom);
    r.ys     = COORD_BITS'($urandom);
    r.xe     = COORD_BITS'($urandom);
    r.ye     = COORD_BITS'($urandom);
    r.colour = $urandom;
    pending_items.push_back(r);
    items_queued++;
  endtask

  // Wait for the pipeline to empty, then allow a load still in its division to finish.
  task automatic drain();
    while (!(pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0))
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both screen registers, one write each; only called with the block idle
  task automatic write_screen(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk_i);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    screen_w = w;
    screen_h = h;
  endtask

  task automatic compare_field(input string name, input logic [31:0] expd,
                               input logic [31:0] actual);
    if (actual !== expd) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, expd, actual);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: offers queued transactions, holds valid and payload until taken
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (dda_advance(on_wire, next_pixel)) expected_pixels.push_back(next_pixel);
      end
      if (in_valid && !in_ready_o) begin
        // still waiting on the handshake: leave everything as it is
      end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_wire = pending_items.pop_front();
        in_valid  <= 1'b1;
        req_type  <= on_wire.req;
        x_start   <= on_wire.xs;
        y_start   <= on_wire.ys;
        x_end     <= on_wire.xe;
        y_end     <= on_wire.ye;
        colour_in <= on_wire.colour;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: checks each pixel against the oldest prediction and drives ready
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d", $time,
                   $signed(pixel_x_o), $signed(pixel_y_o));
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_x", 32'(want.x), 32'(pixel_x_o));
          compare_field("pixel_y", 32'(want.y), 32'(pixel_y_o));
          compare_field("pixel_address", 32'(want.addr), 32'(pixel_address_o));
          compare_field("visible", 32'(want.vis), 32'(visible_o));
          compare_field("write_color", want.colour, write_color_o);
          compare_field("last_pixel", 32'(want.last), 32'(last_pixel_o));
        end
        // long back-pressure so the output register fills and the input stalls
        if (pixels_seen == 400 || pixels_seen == 1000) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence: reset, directed lines at the reset screen size, then random phases
  // ---------------------------------------------------------------------------------------
  initial begin
    int goal;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // step with nothing loaded: no pixel
    queue_step();
    // zero-length line: start pixel once, flagged last; the second step finds it idle
    queue_line(5, 7, 5, 7, 32'hFFFF_FFFF, 2);
    // horizontal line from the origin
    queue_line(0, 0, 3, 0, 32'h0000_0000, 4);
    // half-pixel x increments going negative: -0.5 must round to -1
    queue_line(0, 0, -1, 2, 32'h1234_5678, 3);
    // full-range diagonals, each replaced by the next load mid-line
    queue_line(-2048, -2048, 2047, 2047, 32'hA5A5_A5A5, 2);
    queue_line(2047, 2047, -2048, -2048, 32'h5A5A_5A5A, 2);
    queue_line(2047, -2048, -2048, 2047, 32'h8000_0001, 1);
    // last visible corner, then just off screen
    queue_line(799, 599, 800, 600, 32'h7FFF_FFFE, 2);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin w = 12'd2048; h = 12'd2048; end
        1: begin w = 12'd1;    h = 12'd1;    end
        2: begin w = 12'd0;    h = 12'd0;    end   // nothing visible
        3: begin w = 12'd4095; h = 12'd4095; end   // address wraps to 22 bits
        4: begin w = 12'd320;  h = 12'd240;  end
        default: begin
          w = DIM_BITS'($urandom_range(1, 2048));
          h = DIM_BITS'($urandom_range(1, 2048));
        end
      endcase
      write_screen(w, h);
      // first phase runs with no idling on either side
      send_idle_pct = (ph == 0) ? 0 : 17;
      recv_idle_pct = (ph == 0) ? 0 : 17;
      goal = items_queued + RANDOM_ITEMS / NUM_PHASES;
      while (items_queued < goal) begin
        if ($urandom_range(9) == 0) queue_noise();
        else queue_random_line();
      end
    end

    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dda_lr_pkg.sv
hw/rtl/dda_line_rasterizer.sv
hw/rtl/dda_lr_checker.sv
sim/dda_line_rasterizer_tb.sv
